[hdl/vicm_pkg.sv]
// Shared types, codes and helper functions for the vector integer compare-to-mask block.
package vicm_pkg;

  // Lane and element geometry
  localparam int MaxLanesDefault = 4;
  localparam int DwordW          = 32;
  localparam int DwordsPerLane   = 4;
  localparam int QwordsPerLane   = 2;
  localparam int MaskW           = 16;
  localparam int KindW           = 2;
  localparam int PredW           = 3;
  localparam int TdataW          = 280;

  // Element kinds
  localparam logic [KindW-1:0] KIND_SDWORD = 2'd0;
  localparam logic [KindW-1:0] KIND_UDWORD = 2'd1;
  localparam logic [KindW-1:0] KIND_SQWORD = 2'd2;
  localparam logic [KindW-1:0] KIND_UQWORD = 2'd3;

  // Compare predicates
  localparam logic [PredW-1:0] PRED_EQ    = 3'd0;
  localparam logic [PredW-1:0] PRED_LT    = 3'd1;
  localparam logic [PredW-1:0] PRED_LE    = 3'd2;
  localparam logic [PredW-1:0] PRED_FALSE = 3'd3;
  localparam logic [PredW-1:0] PRED_NE    = 3'd4;
  localparam logic [PredW-1:0] PRED_GE    = 3'd5;
  localparam logic [PredW-1:0] PRED_GT    = 3'd6;
  localparam logic [PredW-1:0] PRED_TRUE  = 3'd7;

  // Result of one 32-bit compare slice, or of a merged qword compare
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

  // True for a dword element kind
  function automatic logic is_dword(input logic [KindW-1:0] kind);
    return (kind == KIND_SDWORD) || (kind == KIND_UDWORD);
  endfunction

  // Evaluate a predicate from equal / less-than flags
  function automatic logic pred_holds(input logic [PredW-1:0] pred, input cmp_t c);
    logic r;
    unique case (pred)
      PRED_EQ:    r = c.eq;
      PRED_LT:    r = c.lt;
      PRED_LE:    r = c.lt | c.eq;
      PRED_FALSE: r = 1'b0;
      PRED_NE:    r = ~c.eq;
      PRED_GE:    r = ~c.lt;
      PRED_GT:    r = ~(c.lt | c.eq);
      PRED_TRUE:  r = 1'b1;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[hdl/vector_int_compare_to_mask_core.sv]
// Top level of the vector integer compare-to-mask block.
//
//  channel  dir  handshake          payload
//  s        in   s_tvalid/s_tready  s_tdata, s_tuser (kind), s_tlast (last lane)
//  m        out  m_tvalid/m_tready  m_tdata (result mask)
//
// One 128-bit lane is taken per cycle while s_tready is high; the four 32-bit compare slices and the
// merge stage finish it in that cycle, so the rate is one transaction per clock when not stalled.
// A result appears in the cycle after the last-lane transaction, from an output register.
// s_tready drops only while that register is full and m_tready is low.
// rst is synchronous; it clears the accumulator, lane counter and output valid.
module vector_int_compare_to_mask_core
  import vicm_pkg::*;
#(
  parameter int MAX_LANES = MaxLanesDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // a_low[63:0], a_high[127:64], b_low[191:128], b_high[255:192],
  // predicate[258:256], mask_enable[259], write_mask[275:260], zeros[279:276]
  input  logic [TdataW-1:0] s_tdata,
  // element kind[1:0]
  input  logic [KindW-1:0]  s_tuser,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  // result_mask[15:0]
  output logic [MaskW-1:0]  m_tdata
);

  logic [DwordW-1:0] a_dw [DwordsPerLane];
  logic [DwordW-1:0] b_dw [DwordsPerLane];
  logic              sign_dw;
  logic              sign_qw;
  cmp_t              slice [DwordsPerLane];
  logic              accept;

  // Unpack dword elements
  always_comb begin
    for (int e = 0; e < DwordsPerLane; e++) begin
      a_dw[e] = s_tdata[e*DwordW +: DwordW];
      b_dw[e] = s_tdata[128 + e*DwordW +: DwordW];
    end
  end

  assign sign_dw = (s_tuser == KIND_SDWORD);
  assign sign_qw = (s_tuser == KIND_SQWORD);
  assign accept  = s_tvalid & s_tready;

  // Parallel compare slices; for qwords only the high slice carries the sign
  for (genvar g = 0; g < DwordsPerLane; g++) begin : g_slice
    vicm_lane u_lane (
      .a    (a_dw[g]),
      .b    (b_dw[g]),
      .flip (sign_dw | (sign_qw & (g % 2 == 1))),
      .cmp  (slice[g])
    );
  end

  vicm_merge #(
    .MAX_LANES (MAX_LANES)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .slice       (slice),
    .kind        (s_tuser),
    .pred        (s_tdata[258:256]),
    .mask_enable (s_tdata[259]),
    .write_mask  (s_tdata[275:260]),
    .last_lane   (s_tlast),
    .accept      (accept),
    .ready       (s_tready),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result      (m_tdata)
  );

endmodule

[hdl/vicm_lane.sv]
// One 32-bit compare slice: equality and ordering with optional sign-bit flip.
module vicm_lane
  import vicm_pkg::*;
(
  input  logic [DwordW-1:0] a,
  input  logic [DwordW-1:0] b,
  input  logic              flip,
  output cmp_t              cmp
);

  logic [DwordW-1:0] x;
  logic [DwordW-1:0] y;

  // Flipping the top bit maps signed order onto unsigned order
  assign x = {a[DwordW-1] ^ flip, a[DwordW-2:0]};
  assign y = {b[DwordW-1] ^ flip, b[DwordW-2:0]};

  assign cmp.eq = (x == y);
  assign cmp.lt = (x < y);

endmodule

[hdl/vicm_merge.sv]
// Merge stage: combines slice results into element bits, gathers the mask, holds the result.
module vicm_merge
  import vicm_pkg::*;
#(
  parameter int MAX_LANES = MaxLanesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmp_t                 slice [DwordsPerLane],
  input  logic [KindW-1:0]     kind,
  input  logic [PredW-1:0]     pred,
  input  logic                 mask_enable,
  input  logic [MaskW-1:0]     write_mask,
  input  logic                 last_lane,
  input  logic                 accept,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MaskW-1:0]     result
);

  localparam int CntW = $clog2(MAX_LANES + 1);

  logic [MaskW-1:0] acc;
  logic [MaskW-1:0] acc_next;
  logic [CntW-1:0]  cnt;
  logic [1:0]       idx;
  logic [3:0]       bits;
  logic [MaskW-1:0] placed;
  logic [MaskW-1:0] wm_sel;
  cmp_t             qcmp [QwordsPerLane];
  logic             room;

  // Qword compare from its high and low dword slices
  always_comb begin
    for (int q = 0; q < QwordsPerLane; q++) begin
      qcmp[q].eq = slice[2*q+1].eq & slice[2*q].eq;
      qcmp[q].lt = slice[2*q+1].lt | (slice[2*q+1].eq & slice[2*q].lt);
    end
  end

  // Per-element predicate bits
  always_comb begin
    bits = '0;
    if (is_dword(kind)) begin
      for (int e = 0; e < DwordsPerLane; e++) begin
        bits[e] = pred_holds(pred, slice[e]);
      end
    end else begin
      for (int e = 0; e < QwordsPerLane; e++) begin
        bits[e] = pred_holds(pred, qcmp[e]);
      end
    end
  end

  // Place the lane's bits at 4n or 2n
  assign room = (cnt < CntW'(MAX_LANES));
  assign idx  = 2'(cnt);
  always_comb begin
    if (is_dword(kind)) begin
      placed = {12'b0, bits} << {idx, 2'b00};
    end else begin
      placed = {14'b0, bits[1:0]} << {idx, 1'b0};
    end
    acc_next = room ? (acc | placed) : acc;
    wm_sel   = is_dword(kind) ? write_mask : {8'b0, write_mask[7:0]};
  end

  // Input side stalls only while a finished result waits and is not taken
  assign ready = ~out_valid | out_ready;

  // Accumulator and lane counter
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (accept) begin
      if (last_lane) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= acc_next;
        if (room) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_lane) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_lane) begin
      result <= mask_enable ? (acc_next & wm_sel) : acc_next;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(MAX_LANES))
    else $error("lane counter beyond lane limit");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_lane |=> cnt == '0 && acc == '0)
    else $error("state not cleared after last lane");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    accept && last_lane |=> out_valid)
    else $error("no result after last lane");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !ready)
    else $error("ready while result is stalled");

endmodule
